// ----- rtl/ihex_pkg.sv -----
// Package for the Intel HEX record encoder.
// Holds the record size, the sequencer types and the character helpers.
// No dependencies.
package ihex_pkg;

    // Data bytes per full record
    localparam int RECORD_BYTES = 16;
    localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W        = $clog2(RECORD_BYTES);

    // Characters in the end-of-file record including newline
    localparam int EOF_CHARS = 12;
    localparam int EOF_W     = $clog2(EOF_CHARS);

    // Input operation codes
    localparam logic [1:0] OP_DATA      = 2'd0;
    localparam logic [1:0] OP_DATA_LAST = 2'd1;
    localparam logic [1:0] OP_END       = 2'd2;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_A       = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLON,
        ST_HI,
        ST_LO,
        ST_NL,
        ST_EOF
    } seq_state_t;

    // Byte of the data record currently being sent
    typedef enum logic [2:0] {
        F_LEN,
        F_ADDR_HI,
        F_ADDR_LO,
        F_TYPE,
        F_DATA,
        F_CSUM
    } rec_field_t;

    // One character from the sequencer toward the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
    } char_emit_t;

    // Text of the end-of-file record ":00000001FF\n"
    function automatic logic [7:0] eof_char(input logic [EOF_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            EOF_W'(0):  c = CH_COLON;
            EOF_W'(8):  c = CH_ONE;
            EOF_W'(9):  c = CH_F;
            EOF_W'(10): c = CH_F;
            EOF_W'(11): c = CH_NEWLINE;
            default:    c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ihex_hex.sv -----
// Shared byte unit: upper-case hex digit of one nibble and checksum add.
// Depends on ihex_pkg.
module ihex_hex
    import ihex_pkg::*;
(
    input  logic [7:0] value,
    input  logic       sel_lo,
    input  logic [7:0] acc,
    output logic [7:0] ascii,
    output logic [7:0] sum
);

    logic [3:0] nib;

    // Nibble pick and digit conversion
    always_comb
    begin
        nib = sel_lo ? value[3:0] : value[7:4];
        if (nib < 4'd10)
            ascii = CH_ZERO + {4'd0, nib};
        else
            ascii = CH_A + {4'd0, nib} - 8'd10;
    end

    // Running checksum, modulo 256
    assign sum = acc + value;

endmodule

// ----- rtl/ihex_seq.sv -----
// Record sequencer: byte buffer, fill count, record address, checksum
// and the state machine that sends one character per step.
// Depends on ihex_pkg and ihex_hex.
module ihex_seq
    import ihex_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       op,
    input  logic [7:0]       data_byte,
    output logic             in_stall,
    input  logic             advance,
    input  logic [15:0]      start_addr,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    output char_emit_t       emit
);

    seq_state_t          state_reg, state_next;
    rec_field_t          field_reg, field_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [15:0]         addr_reg, addr_next;
    logic [7:0]          acc_reg, acc_next;
    logic                open_reg, open_next;
    logic                eof_pend_reg, eof_pend_next;
    logic [EOF_W-1:0]    eof_idx_reg, eof_idx_next;

    logic [7:0]          buf_mem [RECORD_BYTES];

    logic                accept;
    logic                take_byte;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   idx_inc;
    logic [7:0]          cur_byte;
    logic [7:0]          hex_char;
    logic [7:0]          hex_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign take_byte = accept && (op == OP_DATA || op == OP_DATA_LAST);
    assign fill_inc  = fill_reg + FILL_W'(1);
    assign idx_inc   = FILL_W'(idx_reg) + FILL_W'(1);

    // Byte under conversion
    always_comb
    begin
        case (field_reg)
            F_LEN:     cur_byte = 8'(fill_reg);
            F_ADDR_HI: cur_byte = addr_reg[15:8];
            F_ADDR_LO: cur_byte = addr_reg[7:0];
            F_DATA:    cur_byte = buf_mem[idx_reg];
            F_CSUM:    cur_byte = 8'd0 - acc_reg;
            default:   cur_byte = 8'd0;
        endcase
    end

    ihex_hex u_hex (
        .value  (cur_byte),
        .sel_lo (state_reg == ST_LO),
        .acc    (acc_reg),
        .ascii  (hex_char),
        .sum    (hex_sum)
    );

    // Byte buffer
    always_ff @(posedge clk)
    begin
        if (take_byte)
            buf_mem[fill_reg[IDX_W-1:0]] <= data_byte;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            field_reg    <= F_LEN;
            idx_reg      <= '0;
            fill_reg     <= '0;
            addr_reg     <= 16'h0100;
            acc_reg      <= '0;
            open_reg     <= 1'b0;
            eof_pend_reg <= 1'b0;
            eof_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            field_reg    <= field_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            addr_reg     <= addr_next;
            acc_reg      <= acc_next;
            open_reg     <= open_next;
            eof_pend_reg <= eof_pend_next;
            eof_idx_reg  <= eof_idx_next;
        end
    end

    // Next state and character output
    always_comb
    begin
        state_next    = state_reg;
        field_next    = field_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        acc_next      = acc_reg;
        open_next     = open_reg;
        eof_pend_next = eof_pend_reg;
        eof_idx_next  = eof_idx_reg;
        emit          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Address follows the start register while no stream is open
                if (cfg_wr_en && !open_reg)
                    addr_next = cfg_wr_data;
                if (take_byte)
                begin
                    open_next = 1'b1;
                    fill_next = fill_inc;
                    if (fill_inc == FILL_W'(RECORD_BYTES) || op == OP_DATA_LAST)
                    begin
                        state_next    = ST_COLON;
                        field_next    = F_LEN;
                        acc_next      = '0;
                        eof_pend_next = (op == OP_DATA_LAST);
                    end
                end
                else if (accept && op == OP_END)
                begin
                    if (fill_reg != '0)
                    begin
                        state_next    = ST_COLON;
                        field_next    = F_LEN;
                        acc_next      = '0;
                        eof_pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next   = ST_EOF;
                        eof_idx_next = '0;
                    end
                end
            end

            ST_COLON:
            begin
                emit.valid = advance;
                emit.ch    = CH_COLON;
                if (advance)
                    state_next = ST_HI;
            end

            ST_HI:
            begin
                emit.valid = advance;
                emit.ch    = hex_char;
                if (advance)
                    state_next = ST_LO;
            end

            ST_LO:
            begin
                emit.valid = advance;
                emit.ch    = hex_char;
                if (advance)
                begin
                    state_next = ST_HI;
                    if (field_reg != F_CSUM)
                        acc_next = hex_sum;
                    case (field_reg)
                        F_LEN:     field_next = F_ADDR_HI;
                        F_ADDR_HI: field_next = F_ADDR_LO;
                        F_ADDR_LO: field_next = F_TYPE;
                        F_TYPE:
                        begin
                            field_next = F_DATA;
                            idx_next   = '0;
                        end
                        F_DATA:
                        begin
                            if (idx_inc == fill_reg)
                                field_next = F_CSUM;
                            else
                                idx_next = idx_inc[IDX_W-1:0];
                        end
                        default: state_next = ST_NL;
                    endcase
                end
            end

            ST_NL:
            begin
                emit.valid = advance;
                emit.ch    = CH_NEWLINE;
                emit.last  = !eof_pend_reg;
                if (advance)
                begin
                    addr_next = addr_reg + 16'(fill_reg);
                    fill_next = '0;
                    if (eof_pend_reg)
                    begin
                        state_next   = ST_EOF;
                        eof_idx_next = '0;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_EOF:
            begin
                emit.valid = advance;
                emit.ch    = eof_char(eof_idx_reg);
                emit.last  = (eof_idx_reg == EOF_W'(EOF_CHARS - 1));
                if (advance)
                begin
                    if (eof_idx_reg == EOF_W'(EOF_CHARS - 1))
                    begin
                        state_next    = ST_IDLE;
                        fill_next     = '0;
                        addr_next     = start_addr;
                        open_next     = 1'b0;
                        eof_pend_next = 1'b0;
                    end
                    else
                        eof_idx_next = eof_idx_reg + EOF_W'(1);
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Checks
    a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> fill_reg < FILL_W'(RECORD_BYTES))
        else $error("buffer full while idle");

    a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HI || state_reg == ST_LO) && field_reg == F_DATA
        |-> FILL_W'(idx_reg) < fill_reg)
        else $error("data index past record length");

    a_eof_follow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NL && advance && eof_pend_reg |=> state_reg == ST_EOF)
        else $error("end-of-file record not started after final data record");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> in_stall && advance)
        else $error("character sent while idle or blocked");

endmodule

// ----- rtl/intel_hex_record_encoder_core.sv -----
// Top level of the Intel HEX record encoder.
// Depends on ihex_pkg and ihex_seq; holds start address and output register.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid / in_stall        op, data_byte
//  out      output     out_valid / out_stall      out_char, last_of_run
//  cfg      input      cfg_wr_en                  cfg_wr_data (start address)
//
// One character leaves per cycle while the output is not stalled; the state
// machine driving the shared hex unit sets this pace. A data record of N bytes
// is 2*N+12 characters, the end-of-file record 12 more; items that send
// nothing raise no stall. Input is stalled until the last character of an item
// has entered the output register. Reset empties the buffer and sets the start
// address to 0x0100. Output stall freezes the sequencer in place.
module intel_hex_record_encoder_core
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last_of_run,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;
    logic [15:0] start_addr_reg;
    logic        advance;
    char_emit_t  emit;

    assign advance = !out_valid_reg || !out_stall;

    ihex_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .op          (op),
        .data_byte   (data_byte),
        .in_stall    (in_stall),
        .advance     (advance),
        .start_addr  (start_addr_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .emit        (emit)
    );

    // Start address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_addr_reg <= 16'h0100;
        else if (cfg_wr_en)
            start_addr_reg <= cfg_wr_data;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= emit.valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance && emit.valid)
        begin
            out_char_reg <= emit.ch;
            out_last_reg <= emit.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

endmodule

// ----- test/tb_intel_hex_record_encoder_core.sv -----
// Testbench for intel_hex_record_encoder_core: byte stream in, Intel HEX text out.
// Predicts every output character in-bench and checks the output character by character.
// Depends on ihex_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_intel_hex_record_encoder_core;
    import ihex_pkg::*;

    // Op code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } hex_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_DATA;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic        last_of_run;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    byte_item_t pending_items[$];
    hex_char_t  expected_chars[$];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  error_count = 0;
    int  cycle_count = 0;

    // Shadow of the encoder state
    logic [15:0] sh_start_addr;
    logic [15:0] sh_rec_addr;
    logic [7:0]  sh_buf [RECORD_BYTES];
    int          sh_fill;
    logic [7:0]  sh_csum;
    bit          sh_open;

    intel_hex_record_encoder_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_of_run(last_of_run),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_ZERO + {4'h0, nib};
        else
            return CH_A + {4'h0, nib} - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c);
        expected_chars.push_back('{ch: c, last: 1'b0});
    endtask

    // Two upper-case digits, summed into the record checksum
    task automatic push_hex(input logic [7:0] v);
        push_char(hex_digit(v[7:4]));
        push_char(hex_digit(v[3:0]));
        sh_csum = sh_csum + v;
    endtask

    task automatic emit_data_record();
        sh_csum = 8'h00;
        push_char(CH_COLON);
        push_hex(8'(sh_fill));
        push_hex(sh_rec_addr[15:8]);
        push_hex(sh_rec_addr[7:0]);
        push_hex(8'h00);
        for (int i = 0; i < sh_fill; i++)
            push_hex(sh_buf[i]);
        push_hex(8'h00 - sh_csum);
        push_char(CH_NEWLINE);
        sh_rec_addr = sh_rec_addr + 16'(sh_fill);
        sh_fill = 0;
    endtask

    // ":00000001FF" then newline
    task automatic emit_eof_record();
        push_char(CH_COLON);
        for (int i = 0; i < 7; i++)
            push_char(CH_ZERO);
        push_char(CH_ONE);
        push_char(CH_F);
        push_char(CH_F);
        push_char(CH_NEWLINE);
    endtask

    task automatic predict_hex_text(input byte_item_t it);
        int        first_new;
        hex_char_t tail;
        first_new = expected_chars.size();
        if (it.op == OP_UNUSED)
            return;
        if (it.op == OP_DATA || it.op == OP_DATA_LAST)
        begin
            sh_open = 1'b1;
            sh_buf[sh_fill] = it.data;
            sh_fill++;
            if (sh_fill >= RECORD_BYTES)
                emit_data_record();
        end
        if (it.op == OP_DATA_LAST || it.op == OP_END)
        begin
            if (sh_fill > 0)
                emit_data_record();
            emit_eof_record();
            sh_fill = 0;
            sh_rec_addr = sh_start_addr;
            sh_open = 1'b0;
        end
        if (expected_chars.size() > first_new)
        begin
            tail = expected_chars[expected_chars.size() - 1];
            tail.last = 1'b1;
            expected_chars[expected_chars.size() - 1] = tail;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR t=%0t %s: got %02h expected %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: offer the next pending item once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_hex_text('{op: op, data: data_byte});
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                in_valid  <= 1'b1;
                op        <= pending_items[0].op;
                data_byte <= pending_items[0].data;
                void'(pending_items.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted character, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("unexpected character", out_char, 8'h00);
            else
            begin
                if (out_char !== expected_chars[0].ch)
                    report_mismatch("out_char", out_char, expected_chars[0].ch);
                if (last_of_run !== expected_chars[0].last)
                    report_mismatch("last_of_run", {7'h0, last_of_run},
                                    {7'h0, expected_chars[0].last});
                void'(expected_chars.pop_front());
            end
        end
        out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("intel_hex_record_encoder_core: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] o, input logic [7:0] d);
        pending_items.push_back('{op: o, data: d});
    endtask

    // Block idle: nothing pending, nothing in flight, nothing expected
    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_chars.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_address(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sh_start_addr = v;
        if (!sh_open)
            sh_rec_addr = v;
    endtask

    // Mostly whole streams with random bytes; some noise and unterminated streams
    task automatic queue_random_streams(input int n_items);
        int made;
        int len;
        int sel;
        made = 0;
        while (made < n_items)
        begin
            sel = $urandom_range(9);
            if (sel == 0)
                len = 0;
            else if (sel == 1)
                len = 16 * $urandom_range(1, 2);
            else if (sel < 6)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(11) == 0)
                begin
                    queue_item(OP_UNUSED, 8'($urandom));
                    made++;
                end
                queue_item(OP_DATA, 8'($urandom));
                made++;
            end
            if ($urandom_range(5) != 0)
            begin
                queue_item($urandom_range(1) ? OP_DATA_LAST : OP_END, 8'($urandom));
                made++;
            end
        end
    endtask

    // Stimulus sequence
    initial
    begin
        sh_start_addr = 16'h0100;
        sh_rec_addr   = 16'h0100;
        sh_fill       = 0;
        sh_csum       = 8'h00;
        sh_open       = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: end with empty buffer, ignored op, single-byte stream
        queue_item(OP_END, 8'hFF);
        queue_item(OP_UNUSED, 8'hA5);
        queue_item(OP_DATA_LAST, 8'hFF);
        wait_drained();

        // Full record near the top of the address space, then wrap
        write_start_address(16'hFFF8);
        for (int i = 0; i < 16; i++)
            queue_item(OP_DATA, 8'(i * 17));
        queue_item(OP_DATA, 8'h00);
        wait_drained();
        // Stream still open: new start applies to the next stream
        write_start_address(16'h0000);
        queue_item(OP_DATA_LAST, 8'h80);
        queue_item(OP_END, 8'h00);
        wait_drained();

        // Random phases across idling settings and start addresses
        write_start_address(16'hFFFF);
        tx_idle_pct = 0;  rx_stall_pct = 0;
        queue_random_streams(88);
        wait_drained();

        write_start_address(16'($urandom));
        tx_idle_pct = 49; rx_stall_pct = 0;
        queue_random_streams(88);
        wait_drained();

        // Receiver holds off long while the sender keeps offering
        write_start_address(16'h0000);
        tx_idle_pct = 0;  rx_stall_pct = 0;
        queue_random_streams(40);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        wait_drained();

        write_start_address(16'($urandom));
        tx_idle_pct = 0;  rx_stall_pct = 49;
        queue_random_streams(88);
        wait_drained();

        write_start_address(16'hFFF0);
        tx_idle_pct = 35; rx_stall_pct = 35;
        queue_random_streams(88);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("intel_hex_record_encoder_core: match");
        else
            $display("intel_hex_record_encoder_core: mismatch");
        $finish;
    end

endmodule

// ----- intel_hex_record_encoder_core.f -----
rtl/ihex_pkg.sv
rtl/ihex_hex.sv
rtl/ihex_seq.sv
rtl/intel_hex_record_encoder_core.sv
test/tb_intel_hex_record_encoder_core.sv
